// ===== rtl/core/mrkr_pkg.sv =====
`timescale 1ns / 1ps

package mrkr_pkg;

  // Ring depth is a power of two so the slot wrap is a mask.
  localparam int QUEUE_AW     = 6;
  localparam int QUEUE_DEPTH  = 1 << QUEUE_AW;
  localparam int CNT_W        = QUEUE_AW + 1;
  localparam int READER_SLOTS = 16;
  localparam int SLOT_W       = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int VCNT_W       = $clog2(READER_SLOTS + 1);
  localparam int ID_BITS      = 8;
  localparam int SEQ_W        = 32;
  localparam int TAG_W        = 32;
  localparam int LIMIT_W      = 7;

  localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};
  localparam logic [CNT_W-1:0]   KEY_NONE = {CNT_W{1'b1}};

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_AGAIN = 3'd1;
  localparam logic [2:0] ST_GONE  = 3'd2;
  localparam logic [2:0] ST_DEAD  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic CFG_RUNNING = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SUB    = 5'b01000,
    S_MEM    = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/mrkr_store.sv =====
`timescale 1ns / 1ps

module mrkr_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [mrkr_pkg::QUEUE_AW-1:0]   waddr,
  input  logic [mrkr_pkg::TAG_W:0]        wdata,
  input  logic                            re,
  input  logic [mrkr_pkg::QUEUE_AW-1:0]   raddr,
  output logic [mrkr_pkg::TAG_W:0]        rdata
);

  logic [mrkr_pkg::TAG_W:0] mem [mrkr_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mrkr_alu.sv =====
`timescale 1ns / 1ps

module mrkr_alu (
  input  logic [mrkr_pkg::SEQ_W-1:0] a,
  input  logic [mrkr_pkg::SEQ_W-1:0] b,
  input  mrkr_pkg::alu_ctl_t         ctl,
  output logic [mrkr_pkg::SEQ_W-1:0] sum,
  output logic                       eq
);

  assign sum = ctl.sub ? (a - b) : (a + b);
  assign eq  = (a == b);

endmodule

// ===== rtl/core/multi_reader_keyframe_ring.sv =====
`timescale 1ns / 1ps
// Sequence: push, open, drop and reads answered dead, gone or again before the
//   cursor check finish after the reader table scan and the decide step; a read
//   answered again at the cursor check adds the subtract step, and a successful
//   read adds the subtract and memory steps. Open repeats the scan and decide
//   steps for each id skipped after the allocator wraps.
// Pacing: no new item while busy; the reader table scan, one slot a cycle
//   through the shared compare/add unit, sets the pace. Results cannot stall.
// Reset (rst, synchronous): empty ring, no readers, id 0, running 0, limit 64.
module multi_reader_keyframe_ring (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [31:0]                       frame_tag,
  input  logic                              is_keyframe,
  input  logic [7:0]                        reader_id,
  output logic                              done,
  output logic [2:0]                        status,
  output logic [7:0]                        out_reader_id,
  output logic [31:0]                       out_frame_tag,
  output logic                              out_keyframe,
  output logic                              keyframe_request,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [mrkr_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int AW  = mrkr_pkg::QUEUE_AW;
  localparam int CW  = mrkr_pkg::CNT_W;
  localparam int SW  = mrkr_pkg::SLOT_W;
  localparam int NS  = mrkr_pkg::READER_SLOTS;
  localparam int IW  = mrkr_pkg::ID_BITS;
  localparam int QW  = mrkr_pkg::SEQ_W;

  // Configuration registers
  logic                           running;
  logic [mrkr_pkg::LIMIT_W-1:0]   queue_limit;

  // Ring bookkeeping
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [QW-1:0] oldest;
  logic [CW-1:0] key_slot;

  // Reader table
  logic          r_valid  [NS];
  logic [IW-1:0] r_ident  [NS];
  logic          r_placed [NS];
  logic [QW-1:0] r_cursor [NS];

  // Id allocator
  logic [IW-1:0] next_id;
  logic          wrapped;

  // Latched item and scan results
  mrkr_pkg::state_t state;
  logic [1:0]         op_mode;
  logic               key_l;
  logic [7:0]         rid_l;
  logic               evict;
  logic [SW-1:0]      scan_idx;
  logic               found;
  logic [SW-1:0]      fidx;
  logic               cap_placed;
  logic [QW-1:0]      cap_cursor;
  logic               free_found;
  logic [SW-1:0]      free_idx;
  logic [mrkr_pkg::VCNT_W-1:0] vcnt;

  // Shared unit
  logic [QW-1:0]      alu_a, alu_b, alu_sum;
  logic               alu_eq;
  mrkr_pkg::alu_ctl_t alu_ctl;

  // Store ports
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [mrkr_pkg::TAG_W:0] st_rdata;

  logic [CW-1:0] lim;
  logic          accept;
  logic          scan_last;
  logic          full;

  assign cfg_ready = 1'b1;
  assign busy      = (state != mrkr_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign scan_last = (scan_idx == SW'(NS - 1));
  assign full      = (32'(vcnt) >= 32'(mrkr_pkg::ID_MAX)) || !free_found;

  // Clamp the limit to 1..QUEUE_DEPTH.
  always_comb begin
    if (queue_limit == '0) begin
      lim = CW'(1);
    end else if (32'(queue_limit) > mrkr_pkg::QUEUE_DEPTH) begin
      lim = CW'(mrkr_pkg::QUEUE_DEPTH);
    end else begin
      lim = CW'(queue_limit);
    end
  end

  // Write the pushed frame on accept, at the slot past the newest frame.
  assign st_we    = accept && (mode == mrkr_pkg::MODE_PUSH);
  assign st_waddr = head + count[AW-1:0];

  // Operand selection for the shared unit, by step.
  always_comb begin
    alu_a       = oldest;
    alu_b       = QW'(1);
    alu_ctl.sub = 1'b0;
    unique case (state)
      mrkr_pkg::S_SCAN: begin
        if (op_mode == mrkr_pkg::MODE_PUSH) begin
          alu_a = r_cursor[scan_idx];
          alu_b = oldest;
        end else begin
          alu_a = QW'(r_ident[scan_idx]);
          alu_b = (op_mode == mrkr_pkg::MODE_OPEN) ? QW'(next_id) : QW'(rid_l);
        end
      end
      mrkr_pkg::S_DECIDE: begin
        alu_a = oldest;
        alu_b = (op_mode == mrkr_pkg::MODE_PUSH) ? QW'(1) : QW'(key_slot);
      end
      mrkr_pkg::S_SUB: begin
        alu_a       = cap_cursor;
        alu_b       = oldest;
        alu_ctl.sub = 1'b1;
      end
      mrkr_pkg::S_MEM: begin
        alu_a = cap_cursor;
        alu_b = QW'(1);
      end
      default: begin
        alu_a = oldest;
      end
    endcase
  end

  mrkr_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .ctl (alu_ctl),
    .sum (alu_sum),
    .eq  (alu_eq)
  );

  // Frame offset of the reader cursor, valid in the subtract step.
  assign st_re    = (state == mrkr_pkg::S_SUB);
  assign st_raddr = head + alu_sum[AW-1:0];

  mrkr_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({is_keyframe, frame_tag}),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      queue_limit <= mrkr_pkg::LIMIT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrkr_pkg::CFG_RUNNING: running     <= cfg_data[0];
        mrkr_pkg::CFG_LIMIT:   queue_limit <= cfg_data;
        default:               running     <= running;
      endcase
    end
  end

  // Reader table payload: ident, placement and cursor need no reset.
  always_ff @(posedge clk) begin
    if (state == mrkr_pkg::S_DECIDE && op_mode == mrkr_pkg::MODE_OPEN
        && !full && !(wrapped && found)) begin
      r_ident[free_idx]  <= next_id;
      r_placed[free_idx] <= (key_slot != mrkr_pkg::KEY_NONE);
      r_cursor[free_idx] <= (key_slot != mrkr_pkg::KEY_NONE) ? alu_sum : '0;
    end else if (state == mrkr_pkg::S_DECIDE && op_mode == mrkr_pkg::MODE_READ
                 && running && found && !cap_placed
                 && key_slot != mrkr_pkg::KEY_NONE) begin
      r_placed[fidx] <= 1'b1;
      r_cursor[fidx] <= alu_sum;
    end else if (state == mrkr_pkg::S_MEM) begin
      r_cursor[fidx] <= alu_sum;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mrkr_pkg::S_IDLE;
      done     <= 1'b0;
      head     <= '0;
      count    <= '0;
      oldest   <= '0;
      key_slot <= mrkr_pkg::KEY_NONE;
      next_id  <= '0;
      wrapped  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        r_valid[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        mrkr_pkg::S_IDLE: begin
          if (accept) begin
            op_mode    <= mode;
            key_l      <= is_keyframe;
            rid_l      <= reader_id;
            evict      <= (count + CW'(1)) > lim;
            scan_idx   <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            vcnt       <= '0;
            state      <= mrkr_pkg::S_SCAN;
          end
        end

        mrkr_pkg::S_SCAN: begin
          // Visit one reader slot per cycle.
          if (r_valid[scan_idx]) begin
            vcnt <= vcnt + mrkr_pkg::VCNT_W'(1);
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx   <= scan_idx;
          end
          if (op_mode == mrkr_pkg::MODE_PUSH) begin
            // Drop readers parked on the frame about to be evicted.
            if (evict && r_valid[scan_idx] && r_placed[scan_idx] && alu_eq) begin
              r_valid[scan_idx] <= 1'b0;
            end
          end else if (r_valid[scan_idx] && alu_eq && !found) begin
            found      <= 1'b1;
            fidx       <= scan_idx;
            cap_placed <= r_placed[scan_idx];
            cap_cursor <= r_cursor[scan_idx];
          end
          scan_idx <= scan_idx + SW'(1);
          if (scan_last) begin
            state <= mrkr_pkg::S_DECIDE;
          end
        end

        mrkr_pkg::S_DECIDE: begin
          status           <= mrkr_pkg::ST_OK;
          out_reader_id    <= '0;
          out_frame_tag    <= '0;
          out_keyframe     <= 1'b0;
          keyframe_request <= 1'b0;
          state            <= mrkr_pkg::S_IDLE;
          done             <= 1'b1;
          unique case (op_mode)
            mrkr_pkg::MODE_PUSH: begin
              if (evict) begin
                head   <= head + AW'(1);
                oldest <= alu_sum;
                if (key_l) begin
                  key_slot <= count - CW'(1);
                end else if (key_slot == '0) begin
                  key_slot <= mrkr_pkg::KEY_NONE;
                end else if (key_slot != mrkr_pkg::KEY_NONE) begin
                  key_slot <= key_slot - CW'(1);
                end
              end else begin
                count <= count + CW'(1);
                if (key_l) begin
                  key_slot <= count;
                end
              end
            end
            mrkr_pkg::MODE_OPEN: begin
              if (full) begin
                status <= mrkr_pkg::ST_FULL;
              end else if (wrapped && found) begin
                // Skip an id still in use and scan again.
                next_id    <= next_id + IW'(1);
                done       <= 1'b0;
                scan_idx   <= '0;
                found      <= 1'b0;
                free_found <= 1'b0;
                vcnt       <= '0;
                state      <= mrkr_pkg::S_SCAN;
              end else begin
                r_valid[free_idx] <= 1'b1;
                out_reader_id     <= 8'(next_id);
                keyframe_request  <= (key_slot == mrkr_pkg::KEY_NONE) && running;
                if (next_id == mrkr_pkg::ID_MAX) begin
                  next_id <= '0;
                  wrapped <= 1'b1;
                end else begin
                  next_id <= next_id + IW'(1);
                end
              end
            end
            mrkr_pkg::MODE_READ: begin
              if (!running) begin
                status <= mrkr_pkg::ST_DEAD;
              end else if (!found) begin
                status <= mrkr_pkg::ST_GONE;
              end else if (!cap_placed && key_slot == mrkr_pkg::KEY_NONE) begin
                status           <= mrkr_pkg::ST_AGAIN;
                keyframe_request <= 1'b1;
              end else begin
                // Place an unplaced reader at the newest keyframe, then fetch.
                if (!cap_placed) begin
                  cap_placed <= 1'b1;
                  cap_cursor <= alu_sum;
                end
                done  <= 1'b0;
                state <= mrkr_pkg::S_SUB;
              end
            end
            mrkr_pkg::MODE_DROP: begin
              if (found) begin
                r_valid[fidx] <= 1'b0;
              end
            end
            default: begin
              status <= mrkr_pkg::ST_OK;
            end
          endcase
        end

        mrkr_pkg::S_SUB: begin
          // Cursor past the newest frame: answer again.
          if (alu_sum >= QW'(count)) begin
            status <= mrkr_pkg::ST_AGAIN;
            done   <= 1'b1;
            state  <= mrkr_pkg::S_IDLE;
          end else begin
            state <= mrkr_pkg::S_MEM;
          end
        end

        mrkr_pkg::S_MEM: begin
          status        <= mrkr_pkg::ST_OK;
          out_frame_tag <= st_rdata[mrkr_pkg::TAG_W-1:0];
          out_keyframe  <= st_rdata[mrkr_pkg::TAG_W];
          done          <= 1'b1;
          state         <= mrkr_pkg::S_IDLE;
        end

        default: begin
          state <= mrkr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // A result only follows work on an item.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != mrkr_pkg::S_IDLE)
    else $error("result without an item in flight");

  // An accepted item always occupies the block in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accept did not start the sequencer");

  // A keyframe request comes only with ok or again.
  a_req_status: assert property (@(posedge clk) disable iff (rst)
    (done && keyframe_request) |->
      (status == mrkr_pkg::ST_OK || status == mrkr_pkg::ST_AGAIN))
    else $error("keyframe request with wrong status");

  // The ring never holds more frames than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= mrkr_pkg::QUEUE_DEPTH)
    else $error("frame count overflow");

endmodule
